### hdl/fke_pkg.sv
// Shared types and constants for the IP flow key extractor.
// No dependencies; used by every module of the block.
package fke_pkg;

    localparam logic [3:0] VER_IPV4 = 4'h4;
    localparam logic [3:0] VER_IPV6 = 4'h6;

    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_IGMP    = 8'd2;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_UDPLITE = 8'd136;

    localparam logic [5:0] V6_TRANSPORT_OFFSET = 6'd40;
    localparam logic [6:0] TCP_FLAGS_OFFSET    = 7'd13;

    localparam int unsigned OUT_DATA_W = 304;
    localparam int unsigned OUT_USER_W = 2;

    typedef enum logic [1:0] {
        VK_UNKNOWN = 2'd0,
        VK_IPV4    = 2'd1,
        VK_IPV6    = 2'd2
    } ver_kind_t;

    // One classified byte: what the back end must do with it.
    typedef struct packed {
        logic [7:0] data;
        logic       eop;
        ver_kind_t  kind;
        logic       cap_proto;
        logic       cap_src;
        logic       cap_dst;
        logic       cap_port;
        logic       cap_flags;
        logic [3:0] addr_idx;   // byte of the 128-bit address, 0 = most significant
        logic [1:0] port_idx;   // byte of the four transport bytes
    } fke_op_t;

endpackage

### hdl/ip_flow_key_extractor.sv
// IP flow key extractor: one packet byte per beat in, one flow record per packet out.
// Throughput is one byte per cycle while the queue has room; the back end retires one
// queued byte per cycle. tlast passes the queue, then the output register, to m_tvalid.
// A record waiting in the output register stalls only end-of-packet bytes; others drain.
// aresetn is synchronous and active low; it empties the queue and clears all fields.
module ip_flow_key_extractor #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream: one packet byte per beat, starting at the first IP header byte.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] pkt_byte
    input  logic         s_tlast,   // end_of_packet
    // Result stream: one flow record per packet.
    output logic         m_tvalid,
    input  logic         m_tready,
    // From bit 0 up: protocol[7:0], src_high[71:8], src_low[135:72], dst_high[199:136],
    // dst_low[263:200], first_port[279:264], second_port[295:280], tcp_flags[303:296].
    output logic [303:0] m_tdata,
    output logic [1:0]   m_tuser    // [0] status, [1] addr_family
);
    import fke_pkg::*;

    // The front end classifies each byte as it is accepted: it knows the offset
    // within the packet, the version and the header length, so it can say which
    // field (if any) the byte belongs to. Several fields may claim the same byte
    // when the header length field is unusually small.
    fke_op_t front_op;
    fke_op_t back_op;
    logic    s_accept;
    logic    q_can_pop;
    logic    back_take;

    assign s_accept = s_tvalid && s_tready;

    fke_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_in (s_tdata),
        .eop_in  (s_tlast),
        .accept  (s_accept),
        .op      (front_op)
    );

    // The queue decouples the two halves, so a record waiting on the output
    // does not immediately push back on the incoming byte stream.
    fke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_accept),
        .push_op  (front_op),
        .can_push (s_tready),
        .pop      (back_take),
        .pop_op   (back_op),
        .can_pop  (q_can_pop)
    );

    // The back end writes each byte into the captured fields; on the last byte
    // of a packet it decodes the protocol, loads the output register with the
    // record and clears the fields for the next packet.
    fke_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (back_op),
        .op_valid  (q_can_pop),
        .op_take   (back_take),
        .rec_valid (m_tvalid),
        .rec_ready (m_tready),
        .rec_data  (m_tdata),
        .rec_user  (m_tuser)
    );

endmodule

### hdl/fke_front.sv
// Front end: tracks the byte offset, version and header length, and tags each byte
// with the fields it lands in. Depends on fke_pkg.
module fke_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      byte_in,
    input  logic            eop_in,
    input  logic            accept,
    output fke_pkg::fke_op_t op
);
    import fke_pkg::*;

    logic [15:0] off_reg, off_next;
    logic [3:0]  ver_reg, ver_next;
    logic [3:0]  hw_reg, hw_next;

    logic        first_byte;
    logic [3:0]  ver;
    logic [3:0]  hw;
    logic        is_v4, is_v6;
    logic [5:0]  base;
    logic [15:0] base_w;
    logic [15:0] rel;
    logic [6:0]  flags_off;

    always_comb begin
        first_byte = (off_reg == 16'd0);
        ver        = first_byte ? byte_in[7:4] : ver_reg;
        hw         = first_byte ? byte_in[3:0] : hw_reg;
        is_v4      = (ver == VER_IPV4);
        is_v6      = (ver == VER_IPV6);
        base       = is_v4 ? {hw, 2'b00} : V6_TRANSPORT_OFFSET;
        base_w     = {10'd0, base};
        rel        = off_reg - base_w;
        flags_off  = {1'b0, base} + TCP_FLAGS_OFFSET;

        op.data      = byte_in;
        op.eop       = eop_in;
        op.kind      = is_v4 ? VK_IPV4 : (is_v6 ? VK_IPV6 : VK_UNKNOWN);
        op.cap_proto = (is_v4 && off_reg == 16'd9) || (is_v6 && off_reg == 16'd6);
        op.cap_src   = (is_v4 && off_reg >= 16'd12 && off_reg <= 16'd15)
                    || (is_v6 && off_reg >= 16'd8 && off_reg <= 16'd23);
        op.cap_dst   = (is_v4 && off_reg >= 16'd16 && off_reg <= 16'd19)
                    || (is_v6 && off_reg >= 16'd24 && off_reg <= 16'd39);
        op.cap_port  = (is_v4 || is_v6) && (off_reg >= base_w) && (rel < 16'd4);
        op.cap_flags = is_v4 && (off_reg == {9'd0, flags_off});
        // IPv4 addresses sit in the lowest four bytes of the 128-bit word.
        // IPv6 source starts at 8 and destination at 24, both 8 modulo 16.
        op.addr_idx  = is_v4 ? {2'b11, off_reg[1:0]} : (off_reg[3:0] - 4'd8);
        op.port_idx  = rel[1:0];
    end

    always_comb begin
        off_next = off_reg;
        ver_next = ver_reg;
        hw_next  = hw_reg;
        if (accept) begin
            if (eop_in) begin
                off_next = 16'd0;
                ver_next = 4'd0;
                hw_next  = 4'd0;
            end else begin
                if (off_reg != 16'hFFFF) begin
                    off_next = off_reg + 16'd1;
                end
                ver_next = ver;
                hw_next  = hw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= 16'd0;
            ver_reg <= 4'd0;
            hw_reg  <= 4'd0;
        end else begin
            off_reg <= off_next;
            ver_reg <= ver_next;
            hw_reg  <= hw_next;
        end
    end

endmodule

### hdl/fke_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on fke_pkg for the entry type.
module fke_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fke_pkg::fke_op_t push_op,
    output logic             can_push,
    input  logic             pop,
    output fke_pkg::fke_op_t pop_op,
    output logic             can_pop
);
    import fke_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    fke_op_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign can_push = (count_reg != FULL);
    assign can_pop  = (count_reg != '0);
    assign pop_op   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/fke_back.sv
// Back end: applies classified bytes to the captured fields and builds the flow
// record into the output register at the end of a packet. Depends on fke_pkg.
module fke_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fke_pkg::fke_op_t                  op,
    input  logic                              op_valid,
    output logic                              op_take,
    output logic                              rec_valid,
    input  logic                              rec_ready,
    output logic [fke_pkg::OUT_DATA_W-1:0]    rec_data,
    output logic [fke_pkg::OUT_USER_W-1:0]    rec_user
);
    import fke_pkg::*;

    logic [7:0]       proto_reg, proto_next;
    logic [15:0][7:0] src_reg, src_next;
    logic [15:0][7:0] dst_reg, dst_next;
    logic [3:0][7:0]  port_reg, port_next;
    logic [7:0]       flags_reg, flags_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic [7:0]       cap_proto_v;
    logic [15:0][7:0] cap_src_v, cap_dst_v;
    logic [3:0][7:0]  cap_port_v;
    logic [7:0]       cap_flags_v;
    logic             out_free;
    logic             st, fam;
    logic [7:0]       r_proto, r_flags;
    logic [63:0]      r_sh, r_sl, r_dh, r_dl;
    logic [15:0]      r_p0, r_p1;

    assign out_free = !out_valid_reg || rec_ready;
    assign op_take  = op_valid && (!op.eop || out_free);

    // Field values including this byte.
    always_comb begin
        cap_proto_v = proto_reg;
        cap_src_v   = src_reg;
        cap_dst_v   = dst_reg;
        cap_port_v  = port_reg;
        cap_flags_v = flags_reg;
        if (op.cap_proto) begin
            cap_proto_v = op.data;
        end
        if (op.cap_src) begin
            cap_src_v[4'd15 - op.addr_idx] = op.data;
        end
        if (op.cap_dst) begin
            cap_dst_v[4'd15 - op.addr_idx] = op.data;
        end
        if (op.cap_port) begin
            cap_port_v[op.port_idx] = op.data;
        end
        if (op.cap_flags) begin
            cap_flags_v = op.data;
        end
    end

    // Record assembly from the updated fields.
    always_comb begin
        st      = 1'b1;
        fam     = 1'b0;
        r_proto = 8'd0;
        r_sh    = 64'd0;
        r_sl    = 64'd0;
        r_dh    = 64'd0;
        r_dl    = 64'd0;
        r_p0    = 16'd0;
        r_p1    = 16'd0;
        r_flags = 8'd0;
        unique case (op.kind)
            VK_IPV4: begin
                st      = 1'b0;
                r_proto = cap_proto_v;
                r_sl    = cap_src_v[7:0];
                r_dl    = cap_dst_v[7:0];
                if (cap_proto_v == PROTO_TCP || cap_proto_v == PROTO_UDP
                        || cap_proto_v == PROTO_UDPLITE) begin
                    r_p0 = {cap_port_v[0], cap_port_v[1]};
                    r_p1 = {cap_port_v[2], cap_port_v[3]};
                    if (cap_proto_v == PROTO_TCP) begin
                        r_flags = cap_flags_v;
                    end
                end else if (cap_proto_v == PROTO_ICMP) begin
                    r_p0 = {8'd0, cap_port_v[0]};
                    r_p1 = {8'd0, cap_port_v[1]};
                end else if (cap_proto_v == PROTO_IGMP) begin
                    r_p0 = {8'd0, cap_port_v[0]};
                end
            end
            VK_IPV6: begin
                st      = 1'b0;
                fam     = 1'b1;
                r_proto = cap_proto_v;
                r_sh    = cap_src_v[15:8];
                r_sl    = cap_src_v[7:0];
                r_dh    = cap_dst_v[15:8];
                r_dl    = cap_dst_v[7:0];
                if (cap_proto_v == PROTO_TCP || cap_proto_v == PROTO_UDP) begin
                    r_p0 = {cap_port_v[0], cap_port_v[1]};
                    r_p1 = {cap_port_v[2], cap_port_v[3]};
                end
            end
            default: begin
                st = 1'b1;
            end
        endcase
    end

    always_comb begin
        proto_next     = proto_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        port_next      = port_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg && !rec_ready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (op_take) begin
            if (op.eop) begin
                // Fields start from zero for the next packet.
                proto_next     = '0;
                src_next       = '0;
                dst_next       = '0;
                port_next      = '0;
                flags_next     = '0;
                out_valid_next = 1'b1;
                out_data_next  = {r_flags, r_p1, r_p0, r_dl, r_dh, r_sl, r_sh, r_proto};
                out_user_next  = {fam, st};
            end else begin
                proto_next = cap_proto_v;
                src_next   = cap_src_v;
                dst_next   = cap_dst_v;
                port_next  = cap_port_v;
                flags_next = cap_flags_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proto_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            port_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            proto_reg     <= proto_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            port_reg      <= port_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign rec_valid = out_valid_reg;
    assign rec_data  = out_data_reg;
    assign rec_user  = out_user_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ip_flow_key_extractor: streams IPv4, IPv6, foreign and cut-short
// packets one byte per beat and compares every flow record with a predicted one.
// Depends on fke_pkg and the ip_flow_key_extractor RTL only.
module tb;
    import fke_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000; // cycles with no beat on either side
    localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES   = 10;    // settling time after the last record leaves
    localparam int unsigned PHASE_BYTES    = 180;
    localparam int unsigned PHASE_PACKETS  = 5;

    typedef struct {
        bit        status;
        bit        family;
        bit [7:0]  protocol;
        bit [63:0] src_high;
        bit [63:0] src_low;
        bit [63:0] dst_high;
        bit [63:0] dst_low;
        bit [15:0] first_port;
        bit [15:0] second_port;
        bit [7:0]  tcp_flags;
    } flow_record_t;

    // Predicts the flow record of each packet from the bytes seen at the input, and
    // checks the records leaving the block against those predictions in order.
    class flow_record_board;
        bit [15:0]    offset;
        bit [3:0]     version;
        bit [3:0]     ihl;
        bit [7:0]     proto;
        bit [63:0]    src_word[2];
        bit [63:0]    dst_word[2];
        bit [15:0]    ports[2];
        bit [7:0]     flags;
        flow_record_t records_due[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            offset      = '0;
            version     = '0;
            ihl         = '0;
            proto       = '0;
            src_word[0] = '0;
            src_word[1] = '0;
            dst_word[0] = '0;
            dst_word[1] = '0;
            ports[0]    = '0;
            ports[1]    = '0;
            flags       = '0;
        endfunction

        function int unsigned pending();
            return records_due.size();
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            bit [3:0]     ver;
            bit [3:0]     hw;
            bit           known;
            int           off;
            int           base_off;
            int           k;
            flow_record_t rec;

            off = offset;
            // Version and IHL come from byte 0 and already apply to that byte.
            ver = (off == 0) ? b[7:4] : version;
            hw  = (off == 0) ? b[3:0] : ihl;
            if (off == 0) begin
                version = ver;
                ihl     = hw;
            end
            known    = (ver == VER_IPV4) || (ver == VER_IPV6);
            base_off = 0;

            if (ver == VER_IPV4) begin
                if (off == 9)
                    proto = b;
                if (off >= 12 && off <= 15)
                    src_word[1][8 * (15 - off) +: 8] = b;
                if (off >= 16 && off <= 19)
                    dst_word[1][8 * (19 - off) +: 8] = b;
                base_off = hw * 4;
            end else if (ver == VER_IPV6) begin
                if (off == 6)
                    proto = b;
                if (off >= 8 && off <= 23) begin
                    k = off - 8;
                    src_word[k / 8][8 * (7 - k % 8) +: 8] = b;
                end
                if (off >= 24 && off <= 39) begin
                    k = off - 24;
                    dst_word[k / 8][8 * (7 - k % 8) +: 8] = b;
                end
                base_off = V6_TRANSPORT_OFFSET;
            end

            // A small IHL lets the transport window overlap the header; bytes count twice.
            if (known) begin
                if (off >= base_off && off < base_off + 4) begin
                    k = off - base_off;
                    if (k % 2 == 1)
                        ports[k / 2][7:0] = b;
                    else
                        ports[k / 2][15:8] = b;
                end
                if (ver == VER_IPV4 && off == base_off + TCP_FLAGS_OFFSET)
                    flags = b;
            end

            if (offset != 16'hFFFF)
                offset = offset + 16'd1;

            if (!last)
                return;

            rec = '{default: '0};
            rec.status = 1'b1;
            if (known) begin
                rec.status   = 1'b0;
                rec.protocol = proto;
                rec.src_low  = src_word[1];
                rec.dst_low  = dst_word[1];
                if (ver == VER_IPV6) begin
                    rec.family   = 1'b1;
                    rec.src_high = src_word[0];
                    rec.dst_high = dst_word[0];
                    if (proto == PROTO_TCP || proto == PROTO_UDP) begin
                        rec.first_port  = ports[0];
                        rec.second_port = ports[1];
                    end
                end else if (proto == PROTO_TCP || proto == PROTO_UDP
                             || proto == PROTO_UDPLITE) begin
                    rec.first_port  = ports[0];
                    rec.second_port = ports[1];
                    if (proto == PROTO_TCP)
                        rec.tcp_flags = flags;
                end else if (proto == PROTO_ICMP) begin
                    rec.first_port  = {8'h00, ports[0][15:8]};
                    rec.second_port = {8'h00, ports[0][7:0]};
                end else if (proto == PROTO_IGMP) begin
                    rec.first_port = {8'h00, ports[0][15:8]};
                end
            end
            records_due.push_back(rec);
            clear_packet();
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
        endtask

        task check_record(logic [303:0] data, logic [1:0] user);
            flow_record_t want;

            if (records_due.size() == 0) begin
                report_mismatch("record with none pending", data[63:0], '0);
                return;
            end
            want = records_due.pop_front();
            if (user[0] !== want.status)
                report_mismatch("status", user[0], want.status);
            if (user[1] !== want.family)
                report_mismatch("addr_family", user[1], want.family);
            if (data[7:0] !== want.protocol)
                report_mismatch("protocol", data[7:0], want.protocol);
            if (data[71:8] !== want.src_high)
                report_mismatch("src_high", data[71:8], want.src_high);
            if (data[135:72] !== want.src_low)
                report_mismatch("src_low", data[135:72], want.src_low);
            if (data[199:136] !== want.dst_high)
                report_mismatch("dst_high", data[199:136], want.dst_high);
            if (data[263:200] !== want.dst_low)
                report_mismatch("dst_low", data[263:200], want.dst_low);
            if (data[279:264] !== want.first_port)
                report_mismatch("first_port", data[279:264], want.first_port);
            if (data[295:280] !== want.second_port)
                report_mismatch("second_port", data[295:280], want.second_port);
            if (data[303:296] !== want.tcp_flags)
                report_mismatch("tcp_flags", data[303:296], want.tcp_flags);
        endtask
    endclass

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [303:0] m_tdata;
    logic [1:0]   m_tuser;

    flow_record_board board = new();

    bit [7:0]    pkt[$];            // packet being built, first IP header byte first
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int unsigned bytes_sent    = 0;
    int unsigned packets_sent  = 0;
    int unsigned quiet_cycles  = 0;

    ip_flow_key_extractor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Beats are taken at the rising edge; the watchdog only sees quiet stretches.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_record(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("[ip_flow_key_extractor] ERROR");
                    $finish;
                end
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Entered and left at a falling edge; holds the beat until it is taken.
    task automatic drive_byte(input bit [7:0] b, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_packet();
        foreach (pkt[i])
            drive_byte(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
        packets_sent++;
    endtask

    // Sender pauses until every predicted record has left the block.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void fill_random(int len);
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void make_ipv4(bit [3:0] hdr_words, bit [7:0] protocol, int len);
        fill_random(len);
        pkt[0] = {VER_IPV4, hdr_words};
        if (len > 9)
            pkt[9] = protocol;
    endfunction

    function automatic void make_ipv6(bit [7:0] next_hdr, int len);
        fill_random(len);
        pkt[0] = {VER_IPV6, 4'($urandom)};
        if (len > 6)
            pkt[6] = next_hdr;
    endfunction

    function automatic void make_foreign(int len);
        bit [3:0] v;
        fill_random(len);
        v = 4'($urandom);
        while (v == VER_IPV4 || v == VER_IPV6)
            v = 4'($urandom);
        pkt[0][7:4] = v;
    endfunction

    function automatic bit [7:0] pick_protocol();
        case ($urandom_range(6))
            0:       return PROTO_ICMP;
            1:       return PROTO_IGMP;
            2:       return PROTO_TCP;
            3:       return PROTO_UDP;
            4:       return PROTO_UDPLITE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        // Complete IPv4 packets, one per protocol class, then the widest header.
        make_ipv4(4'd5, PROTO_TCP, 34);      send_packet();
        make_ipv4(4'd5, PROTO_UDP, 28);      send_packet();
        make_ipv4(4'd5, PROTO_UDPLITE, 28);  send_packet();
        make_ipv4(4'd5, PROTO_ICMP, 24);     send_packet();
        make_ipv4(4'd5, PROTO_IGMP, 24);     send_packet();
        make_ipv4(4'd5, 8'hFF, 30);          send_packet();
        make_ipv4(4'd15, PROTO_TCP, 74);     send_packet();
        // Small IHL: the transport window lands inside the IP header.
        make_ipv4(4'd0, PROTO_TCP, 14);      send_packet();
        make_ipv4(4'd3, PROTO_TCP, 26);      send_packet();
        // Cut short: before the protocol, half-way through a port, before the flags.
        make_ipv4(4'd5, PROTO_TCP, 1);       send_packet();
        make_ipv4(4'd5, PROTO_TCP, 21);      send_packet();
        make_ipv4(4'd5, PROTO_TCP, 33);      send_packet();
        // All-ones and all-zeros contents.
        make_ipv4(4'd5, PROTO_TCP, 34);
        for (int i = 1; i < 34; i++)
            if (i != 9)
                pkt[i] = 8'hFF;
        send_packet();
        make_ipv4(4'd5, PROTO_UDP, 28);
        for (int i = 1; i < 28; i++)
            if (i != 9)
                pkt[i] = 8'h00;
        send_packet();
        // IPv6: ports only for TCP and UDP; one cut inside the first port.
        make_ipv6(PROTO_TCP, 44);         send_packet();
        make_ipv6(PROTO_UDP, 48);         send_packet();
        make_ipv6(PROTO_UDPLITE, 44);     send_packet();
        make_ipv6(PROTO_UDP, 41);         send_packet();
        make_ipv6(PROTO_TCP, 44);
        for (int i = 1; i < 44; i++)
            if (i != 6)
                pkt[i] = 8'hFF;
        send_packet();
        // Unknown versions at both ends of the nibble.
        make_foreign(1);  pkt[0] = 8'h00; send_packet();
        make_foreign(20); pkt[0] = 8'hF5; send_packet();
    endtask

    // Mostly well-formed packets with random content; about a quarter of the IPv4 and IPv6
    // ones are cut short at a random byte, and a few carry a version the block does not know.
    task automatic random_packet();
        int       sel;
        int       full;
        bit [3:0] hdr_words;
        sel = $urandom_range(99);
        if (sel < 50) begin
            hdr_words = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
            full = hdr_words * 4 + 14 + $urandom_range(6);
            if ($urandom_range(3) == 0)
                full = $urandom_range(full, 1);
            make_ipv4(hdr_words, pick_protocol(), full);
        end else if (sel < 85) begin
            full = 44 + $urandom_range(4);
            if ($urandom_range(3) == 0)
                full = $urandom_range(full, 1);
            make_ipv6(pick_protocol(), full);
        end else begin
            make_foreign($urandom_range(24, 1));
        end
        send_packet();
    endtask

    task automatic run_phase(int unsigned src_pct, int unsigned sink_pct);
        int unsigned byte_mark;
        int unsigned pkt_mark;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        byte_mark = bytes_sent;
        pkt_mark  = packets_sent;
        while (bytes_sent - byte_mark < PHASE_BYTES || packets_sent - pkt_mark < PHASE_PACKETS)
            random_packet();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct  = 36;
        sink_idle_pct = 45;
        run_directed();

        // Receiver holds off while tiny packets keep coming, so records back up
        // and the input stalls on end-of-packet beats.
        hold_req = 1'b1;
        repeat (20) begin
            make_foreign($urandom_range(3, 1));
            send_packet();
        end
        wait_drained();

        run_phase(36, 45);
        run_phase(45, 36);
        run_phase(0, 0);

        if (board.mismatches == 0)
            $display("[ip_flow_key_extractor] OK");
        else
            $display("[ip_flow_key_extractor] ERROR");
        $finish;
    end

endmodule
